// ----- src/kstc_pkg.sv -----
// Shared constants for the Kruskal spanning tree cost block.
// Depends on nothing; the top level takes its defaults and widths from here.
package kstc_pkg;

  // Default vertex count of the union-find forest.
  localparam int NODES_DEFAULT = 64;

  // Widths of the request and result fields.
  localparam int COST_IN_W = 16;
  localparam int NODE_W    = 6;
  localparam int COST_W    = 22;

  // Ceiling of the running total.
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

endpackage

// ----- src/kruskal_spanning_tree_cost_top.sv -----
// Kruskal spanning tree step over a union-find parent table held in one memory.
// Each edge walks the parent links from node_u to its root, then from node_v to its root,
// then links the two roots if they differ; a first edge begins with the identity sweep.
// One edge is in work at a time: no request is taken until the last result is registered.
// Reset sweeps the parent memory to identity with the running total at zero,
// and no request is taken until the sweep ends. Depends on kstc_pkg.
module kruskal_spanning_tree_cost_top #(
  parameter int NODES = kstc_pkg::NODES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kstc_pkg::COST_IN_W-1:0] edge_cost,
  input  logic [kstc_pkg::NODE_W-1:0]    node_u,
  input  logic [kstc_pkg::NODE_W-1:0]    node_v,
  input  logic                           first_edge,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           edge_taken,
  output logic [kstc_pkg::COST_W-1:0]    total_cost
);

  localparam int IW = $clog2(NODES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_U_START,
    S_U_WALK,
    S_V_START,
    S_V_WALK,
    S_LINK,
    S_RESULT
  } state_t;

  state_t                           state;
  logic [IW-1:0]                    clr_idx;
  logic                             pending;
  logic [kstc_pkg::COST_W-1:0]      cost_sum;
  logic [kstc_pkg::COST_IN_W-1:0]   cost_q;
  logic [kstc_pkg::NODE_W-1:0]      node_u_q;
  logic [kstc_pkg::NODE_W-1:0]      node_v_q;
  logic [IW-1:0]                    cur;
  logic [IW-1:0]                    root_u;
  logic [IW-1:0]                    root_v;
  logic                             taken_q;

  // Parent memory and its port signals.
  logic [IW-1:0]                    parent_mem [NODES];
  logic [IW-1:0]                    rd_addr;
  logic [IW-1:0]                    rd_q;
  logic                             wr_en;
  logic [IW-1:0]                    wr_addr;
  logic [IW-1:0]                    wr_data;

  logic                             ends_ok;
  logic [kstc_pkg::COST_W:0]        sum_ext;
  logic [kstc_pkg::COST_W-1:0]      sum_next;

  // Requests are taken only when the sequencer is idle.
  assign in_stall = (state != S_IDLE);

  // Both endpoints must lie inside the vertex set.
  assign ends_ok = (32'(node_u_q) < 32'(NODES)) && (32'(node_v_q) < 32'(NODES));

  // Saturating add of the edge cost to the running total.
  assign sum_ext  = {1'b0, cost_sum} + (kstc_pkg::COST_W + 1)'(cost_q);
  assign sum_next = sum_ext[kstc_pkg::COST_W] ? kstc_pkg::COST_MAX
                                              : sum_ext[kstc_pkg::COST_W-1:0];

  // Read address: the start vertex, or the parent just read while walking.
  always_comb begin
    case (state)
      S_U_START: rd_addr = IW'(node_u_q);
      S_V_START: rd_addr = IW'(node_v_q);
      default:   rd_addr = rd_q;
    endcase
  end

  // Writes come from the identity sweep or from linking two roots.
  assign wr_en   = (state == S_CLEAR) || ((state == S_LINK) && (root_u != root_v));
  assign wr_addr = (state == S_CLEAR) ? clr_idx : root_u;
  assign wr_data = (state == S_CLEAR) ? clr_idx : root_v;

  // Parent memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      parent_mem[wr_addr] <= wr_data;
    end
    rd_q <= parent_mem[rd_addr];
  end

  // Sequencer, running total and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pending   <= 1'b0;
      cost_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result is dropped unless the result state reloads it this cycle.
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cost_q   <= edge_cost;
            node_u_q <= node_u;
            node_v_q <= node_v;
            pending  <= 1'b1;
            clr_idx  <= '0;
            state    <= first_edge ? S_CLEAR : S_U_START;
          end
        end
        S_CLEAR: begin
          cost_sum <= '0;
          if (clr_idx == IW'(NODES - 1)) begin
            state <= pending ? S_U_START : S_IDLE;
          end else begin
            clr_idx <= clr_idx + IW'(1);
          end
        end
        S_U_START: begin
          if (ends_ok) begin
            cur   <= IW'(node_u_q);
            state <= S_U_WALK;
          end else begin
            taken_q <= 1'b0;
            state   <= S_RESULT;
          end
        end
        S_U_WALK: begin
          if (rd_q == cur) begin
            root_u <= cur;
            state  <= S_V_START;
          end else begin
            cur <= rd_q;
          end
        end
        S_V_START: begin
          cur   <= IW'(node_v_q);
          state <= S_V_WALK;
        end
        S_V_WALK: begin
          if (rd_q == cur) begin
            root_v <= cur;
            state  <= S_LINK;
          end else begin
            cur <= rd_q;
          end
        end
        S_LINK: begin
          taken_q <= (root_u != root_v);
          if (root_u != root_v) begin
            cost_sum <= sum_next;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            edge_taken <= taken_q;
            total_cost <= cost_sum;
            pending    <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The identity sweep never addresses beyond the vertex set.
  a_clear_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (32'(clr_idx) < 32'(NODES)))
    else $error("clear sweep index beyond vertex set");

  // Every parent link followed during a walk names a real vertex.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_U_WALK) || (state == S_V_WALK)) |-> (32'(rd_q) < 32'(NODES)))
    else $error("parent link beyond vertex set");

  // A new result is only ever loaded from the result state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RESULT))
    else $error("result raised outside result state");

  // The total only grows, except while the forest is being cleared.
  a_sum_grows: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (cost_sum >= $past(cost_sum)))
    else $error("running total decreased outside a clear");
`endif

endmodule
